// ----- rtl/lsvm_pkg.sv -----
// Shared types, constants and the saturation helper of the linear SVM trainer.
`timescale 1ns / 1ps

package lsvm_pkg;

    localparam int DATA_W    = 16;   // feature width, signed Q7.8
    localparam int WEIGHT_W  = 32;   // weight and bias width, signed Q15.16
    localparam int CFG_W     = 16;   // step size and lambda width, unsigned Q0.16
    localparam int COEF_W    = 25;   // shrink coefficient, unsigned Q1.24
    localparam int PROD_W    = WEIGHT_W + DATA_W;          // w*x, Q.24
    localparam int SHRINK_W  = WEIGHT_W + COEF_W + 1;      // w*c, Q.40
    localparam int DTERM_W   = CFG_W + DATA_W + 2;         // step*x with rounding headroom
    localparam int WIDE_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_DATA_W = 40;  // 35 field bits padded to whole bytes

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGULARIZATION = 1'b1;

    localparam logic [CFG_W-1:0] STEP_RESET   = 16'd655;
    localparam logic [CFG_W-1:0] LAMBDA_RESET = 16'd655;

    localparam logic signed [WEIGHT_W-1:0] ONE_Q16     = 32'sd65536;
    localparam logic signed [WEIGHT_W-1:0] NEG_ONE_Q16 = -32'sd65536;

    localparam logic [1:0] LABEL_POS = 2'b01;
    localparam logic [1:0] LABEL_NEG = 2'b11;

    localparam logic REQ_TRAIN    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD
    } state_t;

    // Control handed from the sequencer to every lane.
    typedef struct packed {
        logic load;       // capture the feature of an accepted transaction
        logic mul;        // form the lane products
        logic upd;        // write the new weight
        logic viol;       // margin violated, add the data term
        logic label_pos;  // label +1 when set, -1 otherwise
    } lane_ctrl_t;

    // Clip a wide signed value to the 32-bit signed range.
    function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[WEIGHT_W-1:0];
    endfunction

endpackage

// ----- rtl/lsvm_lane.sv -----
// One feature lane: weight register, lane multipliers and the weight update.
`timescale 1ns / 1ps

module lsvm_lane
    import lsvm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [DATA_W-1:0]   x_in,
    input  logic [COEF_W-1:0]          coef,
    input  logic [CFG_W-1:0]           step,
    output logic signed [PROD_W-1:0]   prod
);

    logic signed [WEIGHT_W-1:0] w_reg, w_next;
    logic signed [DATA_W-1:0]   x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SHRINK_W-1:0] shr_reg;
    logic signed [DTERM_W-1:0]  dterm_reg;

    logic signed [SHRINK_W-1:0] shr_round;
    logic signed [DTERM_W-1:0]  dprod;
    logic signed [WIDE_W-1:0]   shrink_w;
    logic signed [WIDE_W-1:0]   dterm_w;
    logic signed [WIDE_W-1:0]   nw;

    assign prod = prod_reg;

    // Step times feature, rounded half up back to Q.16.
    assign dprod = DTERM_W'(signed'({1'b0, step})) * DTERM_W'(x_reg) + DTERM_W'(128);

    always_comb
    begin
        shr_round = (shr_reg + (SHRINK_W'(1) <<< 23)) >>> 24;
        shrink_w  = WIDE_W'(shr_round);
        dterm_w   = WIDE_W'(dterm_reg);
        nw        = WIDE_W'(w_reg) - shrink_w;
        if (ctrl.viol)
        begin
            if (ctrl.label_pos)
                nw = nw + dterm_w;
            else
                nw = nw - dterm_w;
        end
        w_next = sat32(nw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_reg <= '0;
        else if (ctrl.upd)
            w_reg <= w_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            x_reg <= x_in;
        if (ctrl.mul)
        begin
            prod_reg  <= PROD_W'(w_reg) * PROD_W'(x_reg);
            shr_reg   <= SHRINK_W'(w_reg) * SHRINK_W'(signed'({1'b0, coef}));
            dterm_reg <= dprod >>> 8;
        end
    end

endmodule

// ----- rtl/lsvm_merge.sv -----
// Merging stage: sums the lane products and the bias into the decision value.
`timescale 1ns / 1ps

module lsvm_merge
    import lsvm_pkg::*;
#(
    parameter int FEATURES = 4
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [PROD_W-1:0]   prod [FEATURES],
    input  logic signed [WEIGHT_W-1:0] bias,
    output logic signed [WEIGHT_W-1:0] dec
);

    localparam int ACC_W = PROD_W + $clog2(FEATURES + 1) + 1;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [WEIGHT_W-1:0] dec_reg;

    assign dec = dec_reg;

    always_comb
    begin
        acc = ACC_W'(bias) <<< 8;
        for (int j = 0; j < FEATURES; j++)
            acc = acc + ACC_W'(prod[j]);
        rounded = (acc + ACC_W'(128)) >>> 8;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dec_reg <= sat32(WIDE_W'(rounded));
    end

endmodule

// ----- rtl/linear_svm_sgd_trainer_core.sv -----
// Top level of the online linear SVM trainer with hinge-loss SGD updates.
`timescale 1ns / 1ps
//
//  Channel   Direction  Signals                              Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser    one sample: features, request, label
//  m_*       out        m_tvalid m_tready m_tdata            label, decision value, margin flag
//  cfg_*     in         cfg_we cfg_index cfg_wdata           step size (0), regularisation (1)
//
//  Every transaction passes through capture, lane multiplies, merge sum and update, in order.
//  The weights of one sample are written before the next sample's products are formed.
//  Results sit in an output register, so a sample can be accepted while the previous
//  result waits; the update cycle holds only while that register is still full.
//  Reset clears the weights and bias to zero and loads the default step and lambda.

module linear_svm_sgd_trainer_core
    import lsvm_pkg::*;
#(
    parameter int FEATURES = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Sample stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [DATA_W*FEATURES-1:0]    s_tdata,   // feature_0, feature_1, ... from bit 0
    input  logic [1:0]                    s_tuser,   // req_type, label_positive
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata,   // predicted_label, decision_value,
                                                     // margin_violated, zero padding
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]           step_reg;
    logic [CFG_W-1:0]           lambda_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic [2*CFG_W-1:0]         sl_prod;

    logic                       req_reg;
    logic                       label_reg;
    logic signed [WEIGHT_W-1:0] bias_reg, bias_next;

    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg, out_data_next;

    logic                       accept;
    logic                       fire;
    logic                       viol;
    lane_ctrl_t                 lane_ctrl;

    logic signed [PROD_W-1:0]   prod [FEATURES];
    logic signed [WEIGHT_W-1:0] dec;
    logic signed [WIDE_W-1:0]   bias_sum;

    // Configuration registers; the shrink coefficient 2*step*lambda in Q1.24 is
    // kept registered so that the lanes never see a multiplier chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            lambda_reg <= LAMBDA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:      step_reg   <= cfg_wdata;
                REG_REGULARIZATION: lambda_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    assign sl_prod = step_reg * lambda_reg;

    always_ff @(posedge clk)
    begin
        coef_reg <= sl_prod[2*CFG_W-1:7];
    end

    // Sequencer.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);

    // The margin test uses the saturated decision: y*dec <= 1.0.
    always_comb
    begin
        if (req_reg != REQ_TRAIN)
            viol = 1'b0;
        else if (label_reg)
            viol = (dec <= ONE_Q16);
        else
            viol = (dec >= NEG_ONE_Q16);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_UPD;
            ST_UPD:  if (fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= s_tuser[0];
            label_reg <= s_tuser[1];
        end
    end

    always_comb
    begin
        lane_ctrl.load      = accept;
        lane_ctrl.mul       = (state_reg == ST_MUL);
        lane_ctrl.upd       = fire && (req_reg == REQ_TRAIN);
        lane_ctrl.viol      = viol;
        lane_ctrl.label_pos = label_reg;
    end

    // One lane per feature.
    for (genvar j = 0; j < FEATURES; j++)
    begin : g_lane
        lsvm_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .x_in  (s_tdata[DATA_W*j +: DATA_W]),
            .coef  (coef_reg),
            .step  (step_reg),
            .prod  (prod[j])
        );
    end

    lsvm_merge #(
        .FEATURES (FEATURES)
    ) u_merge
    (
        .clk  (clk),
        .en   (state_reg == ST_SUM),
        .prod (prod),
        .bias (bias_reg),
        .dec  (dec)
    );

    // Bias moves by y*step only when the margin is violated.
    always_comb
    begin
        if (label_reg)
            bias_sum = WIDE_W'(bias_reg) + WIDE_W'(signed'({1'b0, step_reg}));
        else
            bias_sum = WIDE_W'(bias_reg) - WIDE_W'(signed'({1'b0, step_reg}));
        bias_next = sat32(bias_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bias_reg <= '0;
        else if (fire && viol)
            bias_reg <= bias_next;
    end

    // Output register.
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[1:0]   = (dec >= 0) ? LABEL_POS : LABEL_NEG;
        out_data_next[33:2]  = dec;
        out_data_next[34]    = viol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An accepted transaction goes straight into the multiply cycle.
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL))
        else $error("accepted transaction did not enter the multiply cycle");

    // A new result appears only from the update cycle.
    a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result loaded outside the update cycle");

    // A classify transaction leaves the bias untouched.
    a_classify_keeps_bias: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (req_reg == REQ_CLASSIFY)) |=> $stable(bias_reg))
        else $error("classify transaction changed the bias");

    // The label sign agrees with the sign of the reported decision value.
    a_label_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1] == m_tdata[33]))
        else $error("predicted label disagrees with decision sign");

    // The margin flag is never raised for a classify transaction.
    a_no_viol_classify: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && req_reg == REQ_CLASSIFY) |-> !viol)
        else $error("margin flag raised on a classify transaction");

endmodule
